// ===== hdl/qts_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// qts_pkg
// Types and constants shared by the quintic trajectory sampler and its units.
// ----------------------------------------------------------------------------
package qts_pkg;

  localparam int TIME_W     = 48;
  localparam int VAL_W      = 32;
  localparam int DUR_W      = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 48;

  localparam int MUL_A_W    = 64;
  localparam int MUL_B_W    = 33;
  localparam int PROD_W     = MUL_A_W + MUL_B_W;

  localparam int DIV_NUM_W  = 64;
  localparam int DIV_DEN_W  = 32;
  localparam int DIV_CNT_W  = 6;

  localparam int POW_W      = 33;
  localparam int BL_W       = 44;
  localparam int PS_W       = 50;

  localparam logic [MUL_B_W-1:0] US_PER_S = 33'd1000000;
  localparam logic [POW_W-1:0]   ONE_Q32  = 33'h1_0000_0000;

  typedef enum logic [2:0] {
    PH_HELD    = 3'd0,
    PH_BEFORE  = 3'd1,
    PH_MOVING  = 3'd2,
    PH_AFTER   = 3'd3,
    PH_INVALID = 3'd4
  } phase_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_START_X    = 3'd0,
    REG_START_Y    = 3'd1,
    REG_START_Z    = 3'd2,
    REG_END_X      = 3'd3,
    REG_END_Y      = 3'd4,
    REG_END_Z      = 3'd5,
    REG_BEGIN_TIME = 3'd6,
    REG_DURATION   = 3'd7
  } cfg_reg_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_CHECK,
    S_PDIV,
    S_POW,
    S_BLEND,
    S_DVGO,
    S_DVMUL,
    S_DAMUL,
    S_AXIS,
    S_POSMUL,
    S_VELMUL,
    S_VELDIV,
    S_ACCMUL,
    S_ACCDIV1,
    S_Q1MUL,
    S_ACCDIV2,
    S_FIN
  } seq_state_t;

  typedef struct packed {
    logic done;
    logic big;
    logic rem_nz;
  } div_status_t;

endpackage
`default_nettype wire

// ===== hdl/qts_req_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// qts_req_if
// Request channel: one time stamp per item.
// ----------------------------------------------------------------------------
interface qts_req_if import qts_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [TIME_W-1:0] now_time;

  modport source (output valid, output now_time, input ready);
  modport sink (input valid, input now_time, output ready);
endinterface
`default_nettype wire

// ===== hdl/qts_rsp_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// qts_rsp_if
// Response channel: one set point per item.
// ----------------------------------------------------------------------------
interface qts_rsp_if import qts_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [VAL_W-1:0] pos_x;
  logic [VAL_W-1:0] pos_y;
  logic [VAL_W-1:0] pos_z;
  logic [VAL_W-1:0] vel_x;
  logic [VAL_W-1:0] vel_y;
  logic [VAL_W-1:0] vel_z;
  logic [VAL_W-1:0] acc_x;
  logic [VAL_W-1:0] acc_y;
  logic [VAL_W-1:0] acc_z;
  logic             in_motion;
  logic [2:0]       phase;

  modport source (output valid, output pos_x, output pos_y, output pos_z,
                  output vel_x, output vel_y, output vel_z,
                  output acc_x, output acc_y, output acc_z,
                  output in_motion, output phase, input ready);
  modport sink (input valid, input pos_x, input pos_y, input pos_z,
                input vel_x, input vel_y, input vel_z,
                input acc_x, input acc_y, input acc_z,
                input in_motion, input phase, output ready);
endinterface
`default_nettype wire

// ===== hdl/qts_mul.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// qts_mul
// Shift-add unsigned multiplier, one multiplier bit per cycle, stops early
// once the remaining multiplier bits are all zero.
// ----------------------------------------------------------------------------
module qts_mul import qts_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [MUL_A_W-1:0] a,
  input  logic [MUL_B_W-1:0] b,
  output logic               done,
  output logic [PROD_W-1:0]  prod
);

  logic               busy;
  logic [PROD_W-1:0]  acc;
  logic [PROD_W-1:0]  a_sh;
  logic [MUL_B_W-1:0] b_sh;

  assign done = busy && (b_sh == '0);
  assign prod = acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (done) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc  <= '0;
      a_sh <= PROD_W'(a);
      b_sh <= b;
    end else if (busy) begin
      if (b_sh[0]) begin
        acc <= acc + a_sh;
      end
      a_sh <= {a_sh[PROD_W-2:0], 1'b0};
      b_sh <= {1'b0, b_sh[MUL_B_W-1:1]};
    end
  end

endmodule
`default_nettype wire

// ===== hdl/qts_div.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// qts_div
// Restoring divider, one quotient bit per cycle over the full 64-bit
// numerator. Quotients of 2^32 or more are flagged as big.
// ----------------------------------------------------------------------------
module qts_div import qts_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [DIV_NUM_W-1:0] num,
  input  logic [DIV_DEN_W-1:0] den,
  output div_status_t          status,
  output logic [DIV_NUM_W-1:0] quo
);

  logic                 busy;
  logic                 done_r;
  logic [DIV_DEN_W-1:0] rem;
  logic [DIV_NUM_W-1:0] lo;
  logic [DIV_DEN_W-1:0] den_r;
  logic [DIV_CNT_W-1:0] cnt;
  logic [DIV_DEN_W:0]   r2;
  logic [DIV_DEN_W:0]   diff;
  logic                 fits;

  // The partial remainder stays below the divisor, so 33 bits hold the shift.
  assign r2   = {rem, lo[DIV_NUM_W-1]};
  assign fits = r2 >= {1'b0, den_r};
  assign diff = r2 - {1'b0, den_r};

  assign status.done   = done_r;
  assign status.big    = lo[DIV_NUM_W-1:DIV_DEN_W] != '0;
  assign status.rem_nz = rem != '0;
  assign quo           = lo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy   <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy) begin
        if (cnt == DIV_CNT_W'(DIV_NUM_W - 1)) begin
          busy   <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= '0;
      lo    <= num;
      den_r <= den;
      cnt   <= '0;
    end else if (busy) begin
      rem <= fits ? diff[DIV_DEN_W-1:0] : r2[DIV_DEN_W-1:0];
      lo  <= {lo[DIV_NUM_W-2:0], fits};
      cnt <= cnt + 1'b1;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/quintic_trajectory_sampler.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// quintic_trajectory_sampler
// Three-axis quintic smoothstep set point generator with held outputs.
// ----------------------------------------------------------------------------
// One item at a time. An item outside the motion window, with a zero time
// stamp or with a zero duration skips the arithmetic. Inside the window the
// progress is found by a 64-step divider (at the end time the powers are set
// to 1.0 instead), then the powers of the progress, the scaled blend terms
// and per axis the position, velocity and acceleration all run through one
// shift-add multiplier (one multiplier bit per cycle, stopping early) and
// the same 64-step divider, up to three divisions per axis. The request
// channel is ready again once the result has moved into the output register.
module quintic_trajectory_sampler import qts_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  qts_req_if.sink               req,
  qts_rsp_if.source             rsp
);

  localparam logic [VAL_W-1:0] SAT_MAX = 32'h7FFF_FFFF;
  localparam logic [VAL_W-1:0] SAT_MIN = 32'h8000_0000;

  seq_state_t state, state_next;

  logic [VAL_W-1:0]  st_cfg [3];
  logic [VAL_W-1:0]  en_cfg [3];
  logic [TIME_W-1:0] begin_time;
  logic [DUR_W-1:0]  duration;

  logic [TIME_W-1:0] now_r;
  logic [1:0]        axis;
  logic [2:0]        pow_idx;
  logic [POW_W-1:0]  pw [1:5];
  logic [BL_W-1:0]   bl_mag, db_mag, dd_mag;
  logic              bl_neg, db_neg, dd_neg;
  logic [63:0]       dv, da;
  logic [POW_W-1:0]  delta_mag;
  logic              delta_neg;
  logic              inex_r;
  logic [2:0]        phase_r;
  logic              motion_r;
  logic [VAL_W-1:0]  work [9];

  logic              out_valid;
  logic [VAL_W-1:0]  out_val [9];
  logic [2:0]        out_phase;
  logic              out_motion;

  logic               mul_go, mul_done;
  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [PROD_W-1:0]  prod;
  logic               div_go;
  logic [DIV_NUM_W-1:0] div_num;
  div_status_t        dst;
  logic [DIV_NUM_W-1:0] quo;

  logic              before_c, after_c, at_end_c;
  logic [TIME_W-1:0] elapsed_c;
  logic [TIME_W:0]   end_t_c;
  logic [BL_W-1:0]   e1, e2, e3, e4, e5;
  logic [BL_W-1:0]   blend_c, dblend_c, ddblend_c;
  logic [VAL_W-1:0]  st_sel, en_sel;
  logic [POW_W-1:0]  delta_c, dmag_c;
  logic              vneg, aneg, last_axis;
  logic [DIV_NUM_W-1:0] q1mag_c;
  logic              acc_wide_c;
  logic [47:0]       pm_c;
  logic [PS_W-1:0]   px_c, psum_c;
  logic              pneg;
  logic [VAL_W-1:0]  pos_c;
  logic [3:0]        pos_i, vel_i, acc_i;

  function automatic logic [VAL_W-1:0] sat_sm(input logic neg, input logic big,
                                              input logic [POW_W-1:0] mag);
    logic [POW_W-1:0] ng;
    ng = POW_W'(0) - mag;
    if (big) return neg ? SAT_MIN : SAT_MAX;
    if (neg) return (mag > 33'h0_8000_0000) ? SAT_MIN : ng[VAL_W-1:0];
    return (mag > 33'h0_7FFF_FFFF) ? SAT_MAX : mag[VAL_W-1:0];
  endfunction

  qts_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_go),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .prod  (prod)
  );

  qts_div u_div (
    .clk    (clk),
    .rst    (rst),
    .start  (div_go),
    .num    (div_num),
    .den    (duration),
    .status (dst),
    .quo    (quo)
  );

  // Window tests.
  assign before_c  = now_r < begin_time;
  assign end_t_c   = {1'b0, begin_time} + (TIME_W + 1)'(duration);
  assign after_c   = {1'b0, now_r} > end_t_c;
  assign elapsed_c = now_r - begin_time;
  assign at_end_c  = elapsed_c == TIME_W'(duration);

  // Blend polynomials; the powers are at most 1.0 in Q.32.
  assign e1 = BL_W'(pw[1]);
  assign e2 = BL_W'(pw[2]);
  assign e3 = BL_W'(pw[3]);
  assign e4 = BL_W'(pw[4]);
  assign e5 = BL_W'(pw[5]);
  assign blend_c   = BL_W'(6) * e5 - BL_W'(15) * e4 + BL_W'(10) * e3;
  assign dblend_c  = BL_W'(30) * e4 - BL_W'(60) * e3 + BL_W'(30) * e2;
  assign ddblend_c = BL_W'(120) * e3 - BL_W'(180) * e2 + BL_W'(60) * e1;

  assign st_sel  = st_cfg[axis];
  assign en_sel  = en_cfg[axis];
  assign delta_c = {en_sel[VAL_W-1], en_sel} - {st_sel[VAL_W-1], st_sel};
  assign dmag_c  = delta_c[POW_W-1] ? POW_W'(0) - delta_c : delta_c;

  assign vneg      = db_neg ^ delta_neg;
  assign aneg      = dd_neg ^ delta_neg;
  assign last_axis = axis == 2'd2;
  // The intermediate acceleration quotient can exceed 32 bits, so it is kept whole.
  assign q1mag_c   = quo + DIV_NUM_W'(aneg & (inex_r | dst.rem_nz));
  // A scaled intermediate of 2^64 or more divides to far beyond the int32 range.
  assign acc_wide_c = prod[PROD_W-1:DIV_NUM_W] != '0;
  assign pos_i     = 4'(axis);
  assign vel_i     = 4'(axis) + 4'd3;
  assign acc_i     = 4'(axis) + 4'd6;

  // Position: start plus the floored product of blend and delta.
  assign pm_c   = prod[79:32];
  assign pneg   = bl_neg ^ delta_neg;
  assign px_c   = pneg ? PS_W'(0) - (PS_W'(pm_c) + PS_W'(prod[31:0] != '0))
                       : PS_W'(pm_c);
  assign psum_c = {{(PS_W-VAL_W){st_sel[VAL_W-1]}}, st_sel} + px_c;
  always_comb begin
    if (!psum_c[PS_W-1] && (psum_c[PS_W-2:VAL_W-1] != '0)) begin
      pos_c = SAT_MAX;
    end else if (psum_c[PS_W-1] && (psum_c[PS_W-2:VAL_W-1] != '1)) begin
      pos_c = SAT_MIN;
    end else begin
      pos_c = psum_c[VAL_W-1:0];
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        st_cfg[i] <= '0;
        en_cfg[i] <= '0;
      end
      begin_time <= '0;
      duration   <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_START_X:    st_cfg[0]  <= cfg_data[VAL_W-1:0];
        REG_START_Y:    st_cfg[1]  <= cfg_data[VAL_W-1:0];
        REG_START_Z:    st_cfg[2]  <= cfg_data[VAL_W-1:0];
        REG_END_X:      en_cfg[0]  <= cfg_data[VAL_W-1:0];
        REG_END_Y:      en_cfg[1]  <= cfg_data[VAL_W-1:0];
        REG_END_Z:      en_cfg[2]  <= cfg_data[VAL_W-1:0];
        REG_BEGIN_TIME: begin_time <= cfg_data[TIME_W-1:0];
        REG_DURATION:   duration   <= cfg_data[DUR_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    mul_go     = 1'b0;
    mul_a      = '0;
    mul_b      = '0;
    div_go     = 1'b0;
    div_num    = '0;
    case (state)
      S_IDLE: begin
        if (req.valid) state_next = S_CHECK;
      end
      S_CHECK: begin
        if (now_r == '0 || duration == '0 || before_c || after_c) begin
          state_next = S_FIN;
        end else if (at_end_c) begin
          state_next = S_BLEND;
        end else begin
          div_go     = 1'b1;
          div_num    = {elapsed_c[DUR_W-1:0], 32'd0};
          state_next = S_PDIV;
        end
      end
      S_PDIV: begin
        if (dst.done) begin
          mul_go     = 1'b1;
          mul_a      = MUL_A_W'(quo[DIV_DEN_W-1:0]);
          mul_b      = {1'b0, quo[DIV_DEN_W-1:0]};
          state_next = S_POW;
        end
      end
      S_POW: begin
        if (mul_done) begin
          if (pow_idx == 3'd5) begin
            state_next = S_BLEND;
          end else begin
            mul_go = 1'b1;
            mul_a  = MUL_A_W'(prod[63:32]);
            mul_b  = pw[1];
          end
        end
      end
      S_BLEND: state_next = S_DVGO;
      S_DVGO: begin
        mul_go     = 1'b1;
        mul_a      = MUL_A_W'(db_mag);
        mul_b      = US_PER_S;
        state_next = S_DVMUL;
      end
      S_DVMUL: begin
        if (mul_done) begin
          mul_go     = 1'b1;
          mul_a      = MUL_A_W'(dd_mag);
          mul_b      = US_PER_S;
          state_next = S_DAMUL;
        end
      end
      S_DAMUL: begin
        if (mul_done) state_next = S_AXIS;
      end
      S_AXIS: begin
        mul_go     = 1'b1;
        mul_a      = MUL_A_W'(bl_mag);
        mul_b      = dmag_c;
        state_next = S_POSMUL;
      end
      S_POSMUL: begin
        if (mul_done) begin
          mul_go     = 1'b1;
          mul_a      = dv;
          mul_b      = delta_mag;
          state_next = S_VELMUL;
        end
      end
      S_VELMUL: begin
        if (mul_done) begin
          div_go     = 1'b1;
          div_num    = prod[95:32];
          state_next = S_VELDIV;
        end
      end
      S_VELDIV: begin
        if (dst.done) begin
          mul_go     = 1'b1;
          mul_a      = da;
          mul_b      = delta_mag;
          state_next = S_ACCMUL;
        end
      end
      S_ACCMUL: begin
        if (mul_done) begin
          div_go     = 1'b1;
          div_num    = prod[95:32];
          state_next = S_ACCDIV1;
        end
      end
      S_ACCDIV1: begin
        if (dst.done) begin
          mul_go     = 1'b1;
          mul_a      = q1mag_c;
          mul_b      = US_PER_S;
          state_next = S_Q1MUL;
        end
      end
      S_Q1MUL: begin
        if (mul_done) begin
          if (acc_wide_c) begin
            state_next = last_axis ? S_FIN : S_AXIS;
          end else begin
            div_go     = 1'b1;
            div_num    = prod[DIV_NUM_W-1:0];
            state_next = S_ACCDIV2;
          end
        end
      end
      S_ACCDIV2: begin
        if (dst.done) state_next = last_axis ? S_FIN : S_AXIS;
      end
      S_FIN: begin
        if (!out_valid || rsp.ready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Datapath. The working results double as the held outputs.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 9; i++) begin
        work[i] <= '0;
      end
    end else begin
      case (state)
        S_IDLE: begin
          if (req.valid) now_r <= req.now_time;
        end
        S_CHECK: begin
          axis     <= '0;
          pow_idx  <= 3'd2;
          motion_r <= 1'b0;
          if (now_r == '0) begin
            phase_r <= PH_HELD;
          end else if (duration == '0 || before_c || after_c) begin
            if (duration == '0) begin
              phase_r <= PH_INVALID;
            end else if (before_c) begin
              phase_r <= PH_BEFORE;
            end else begin
              phase_r <= PH_AFTER;
            end
            for (int i = 0; i < 3; i++) begin
              work[i] <= (duration != '0 && !before_c) ? en_cfg[i] : st_cfg[i];
            end
            for (int i = 3; i < 9; i++) begin
              work[i] <= '0;
            end
          end else begin
            phase_r  <= PH_MOVING;
            motion_r <= 1'b1;
            if (at_end_c) begin
              for (int i = 1; i <= 5; i++) begin
                pw[i] <= ONE_Q32;
              end
            end
          end
        end
        S_PDIV: begin
          if (dst.done) pw[1] <= {1'b0, quo[DIV_DEN_W-1:0]};
        end
        S_POW: begin
          if (mul_done) begin
            pw[pow_idx] <= {1'b0, prod[63:32]};
            pow_idx     <= pow_idx + 3'd1;
          end
        end
        S_BLEND: begin
          bl_neg <= blend_c[BL_W-1];
          db_neg <= dblend_c[BL_W-1];
          dd_neg <= ddblend_c[BL_W-1];
          bl_mag <= blend_c[BL_W-1] ? BL_W'(0) - blend_c : blend_c;
          db_mag <= dblend_c[BL_W-1] ? BL_W'(0) - dblend_c : dblend_c;
          dd_mag <= ddblend_c[BL_W-1] ? BL_W'(0) - ddblend_c : ddblend_c;
        end
        S_DVMUL: begin
          if (mul_done) dv <= prod[63:0];
        end
        S_DAMUL: begin
          if (mul_done) da <= prod[63:0];
        end
        S_AXIS: begin
          delta_mag <= dmag_c;
          delta_neg <= delta_c[POW_W-1];
        end
        S_POSMUL: begin
          if (mul_done) work[pos_i] <= pos_c;
        end
        S_VELMUL: begin
          if (mul_done) inex_r <= prod[31:0] != '0;
        end
        S_VELDIV: begin
          if (dst.done) begin
            work[vel_i] <= sat_sm(vneg, dst.big,
                                  {1'b0, quo[DIV_DEN_W-1:0]}
                                  + POW_W'(vneg & (inex_r | dst.rem_nz)));
          end
        end
        S_ACCMUL: begin
          if (mul_done) inex_r <= prod[31:0] != '0;
        end
        S_Q1MUL: begin
          if (mul_done && acc_wide_c) begin
            work[acc_i] <= sat_sm(aneg, 1'b1, POW_W'(0));
            axis        <= axis + 2'd1;
          end
        end
        S_ACCDIV2: begin
          if (dst.done) begin
            work[acc_i] <= sat_sm(aneg, dst.big,
                                  {1'b0, quo[DIV_DEN_W-1:0]} + POW_W'(aneg & dst.rem_nz));
            axis        <= axis + 2'd1;
          end
        end
        default: ;
      endcase
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_FIN && (!out_valid || rsp.ready)) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_FIN && (!out_valid || rsp.ready)) begin
      for (int i = 0; i < 9; i++) begin
        out_val[i] <= work[i];
      end
      out_phase  <= phase_r;
      out_motion <= motion_r;
    end
  end

  assign req.ready     = state == S_IDLE;
  assign rsp.valid     = out_valid;
  assign rsp.pos_x     = out_val[0];
  assign rsp.pos_y     = out_val[1];
  assign rsp.pos_z     = out_val[2];
  assign rsp.vel_x     = out_val[3];
  assign rsp.vel_y     = out_val[4];
  assign rsp.vel_z     = out_val[5];
  assign rsp.acc_x     = out_val[6];
  assign rsp.acc_y     = out_val[7];
  assign rsp.acc_z     = out_val[8];
  assign rsp.in_motion = out_motion;
  assign rsp.phase     = out_phase;

endmodule
`default_nettype wire
